[rtl/lss_pkg.sv]
// Shared types, codes and the transition table of the loading-station sequencer.
package lss_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int OPCODE_W    = 3;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 4;

  // fill-offset threshold at or below -10.0 (Q16.16) switches the offset events off
  localparam logic signed [SAMPLE_W-1:0] OFFSET_DISABLE = -32'sd655360;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_READY   = 3'd1,
    ST_EMERG   = 3'd2,
    ST_MANUAL  = 3'd3,
    ST_WORKING = 3'd4,
    ST_CLEANUP = 3'd5,
    ST_ENDING  = 3'd6,
    ST_PAUSED  = 3'd7
  } state_t;

  typedef enum logic [3:0] {
    EV_NONE   = 4'd0,
    EV_EMERG  = 4'd1,
    EV_MANUAL = 4'd2,
    EV_RESET  = 4'd3,
    EV_READY  = 4'd4,
    EV_COME   = 4'd5,
    EV_LEAVE  = 4'd6,
    EV_GONE   = 4'd7,
    EV_LOADED = 4'd8,
    EV_CLEAR  = 4'd9,
    EV_FULL   = 4'd10,
    EV_EMPTY  = 4'd11
  } event_t;

  typedef enum logic [2:0] {
    OP_EMERG   = 3'd0,
    OP_MANUAL  = 3'd1,
    OP_RESET   = 3'd2,
    OP_TRIGGER = 3'd3,
    OP_LOAD    = 3'd4,
    OP_OFFSET  = 3'd5,
    OP_FRONT   = 3'd6,
    OP_TAIL    = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_LOAD_LIMIT   = 3'd0,
    CFG_OFFSET_LIMIT = 3'd1,
    CFG_FRONT_MIN    = 3'd2,
    CFG_FRONT_MAX    = 3'd3,
    CFG_TAIL_MIN     = 3'd4,
    CFG_TAIL_MAX     = 3'd5,
    CFG_VALVE_DEF    = 3'd6
  } cfg_idx_t;

  // classified item handed from front to back
  typedef struct packed {
    event_t ev;
    logic   trig;
  } cmd_t;

  typedef struct packed {
    logic   move;
    state_t nxt;
  } move_t;

  // result beat, current_state in the low bits
  typedef struct packed {
    logic   lidar_disable;
    logic   lidar_enable;
    logic   press_open;
    logic   press_close;
    logic   state_changed;
    event_t event_code;
    state_t current_state;
  } result_t;

  function automatic move_t next_state(state_t s, event_t e);
    move_t m;
    m.move = 1'b0;
    m.nxt  = s;
    unique case (s)
      ST_IDLE: begin
        unique case (e)
          EV_EMERG:  m = '{1'b1, ST_EMERG};
          EV_MANUAL: m = '{1'b1, ST_MANUAL};
          EV_READY:  m = '{1'b1, ST_READY};
          default:   m = '{1'b0, s};
        endcase
      end
      ST_READY: begin
        unique case (e)
          EV_EMERG:  m = '{1'b1, ST_EMERG};
          EV_MANUAL: m = '{1'b1, ST_MANUAL};
          EV_COME:   m = '{1'b1, ST_WORKING};
          default:   m = '{1'b0, s};
        endcase
      end
      ST_EMERG, ST_MANUAL: begin
        if (e == EV_RESET) begin
          m = '{1'b1, ST_IDLE};
        end
      end
      ST_WORKING: begin
        unique case (e)
          EV_EMERG:  m = '{1'b1, ST_EMERG};
          EV_MANUAL: m = '{1'b1, ST_MANUAL};
          EV_LEAVE:  m = '{1'b1, ST_ENDING};
          EV_GONE:   m = '{1'b1, ST_EMERG};
          EV_LOADED: m = '{1'b1, ST_CLEANUP};
          EV_FULL:   m = '{1'b1, ST_PAUSED};
          default:   m = '{1'b0, s};
        endcase
      end
      ST_CLEANUP: begin
        unique case (e)
          EV_EMERG:  m = '{1'b1, ST_EMERG};
          EV_MANUAL: m = '{1'b1, ST_MANUAL};
          EV_CLEAR:  m = '{1'b1, ST_IDLE};
          default:   m = '{1'b0, s};
        endcase
      end
      ST_ENDING: begin
        unique case (e)
          EV_EMERG:  m = '{1'b1, ST_EMERG};
          EV_MANUAL: m = '{1'b1, ST_MANUAL};
          EV_GONE:   m = '{1'b1, ST_EMERG};
          EV_LOADED: m = '{1'b1, ST_CLEANUP};
          EV_FULL:   m = '{1'b1, ST_CLEANUP};
          default:   m = '{1'b0, s};
        endcase
      end
      ST_PAUSED: begin
        unique case (e)
          EV_EMERG:  m = '{1'b1, ST_EMERG};
          EV_MANUAL: m = '{1'b1, ST_MANUAL};
          EV_GONE:   m = '{1'b1, ST_CLEANUP};
          EV_LOADED: m = '{1'b1, ST_CLEANUP};
          EV_EMPTY:  m = '{1'b1, ST_WORKING};
          default:   m = '{1'b0, s};
        endcase
      end
      default: m = '{1'b0, s};
    endcase
    return m;
  endfunction

endpackage

[rtl/loading_station_sequencer.sv]
// Top level of the loading-station sequencer.
// Use: items enter on the in_ stream (opcode in tuser, Q16.16 sample in tdata).
// Commands (emergency, manual, reset, trigger) map straight to events; samples
// are compared with the threshold registers and become at most one event.
// Every item yields exactly one result beat on the out_ stream carrying the
// state after the item, the event, and the valve and lidar action flags.
// Thresholds and the valve flag are written over cfg_ (one write per cycle,
// no read-back); the user must write them only while no item is in flight,
// as the block does not enforce it. A beat is classified and queued at the
// edge that accepts it; the back end pops it and registers its result once
// the output register is free. Throughput: one beat per cycle while out_tready
// is high; the queue decouples input acceptance from output stalls.
// Stall: when out_tready is low the result register holds; the queue keeps
// taking beats until its QDEPTH entries are full, then in_tready drops.
// Reset (rst_n low, synchronous): state idle, no kit selected, queue and
// output empty, registers at their reset values (offset events disabled).
module loading_station_sequencer #(
  parameter int QDEPTH = lss_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // [31:0] sample_value
  input  logic [2:0]                     in_tuser,   // [2:0] opcode
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [2:0] current_state, [6:3] event_code, [7] state_changed,
  // [8] press_close_valve, [9] press_open_valve, [10] lidar_enable,
  // [11] lidar_disable, [15:12] zero
  output logic [15:0]                    out_tdata,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [lss_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lss_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  lss_pkg::cmd_t    front_cmd;
  lss_pkg::cmd_t    q_cmd;
  logic             q_valid;
  logic             q_pop;
  lss_pkg::result_t res;

  // classification is combinational off the beat; the queue registers it
  lss_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .opcode       (in_tuser),
    .sample_value (in_tdata),
    .cmd          (front_cmd)
  );

  lss_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_tvalid),
    .push_data  (front_cmd),
    .push_ready (in_tready),
    .pop        (q_pop),
    .pop_data   (q_cmd),
    .pop_valid  (q_valid)
  );

  // state machine consumes one queued command per cycle unless output stalls
  lss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (q_cmd),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {4'b0000, res};

endmodule

[rtl/lss_front.sv]
// Front end: threshold registers and sample-to-event classification.
module lss_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lss_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [lss_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [lss_pkg::OPCODE_W-1:0]      opcode,
  input  logic signed [lss_pkg::SAMPLE_W-1:0] sample_value,
  output lss_pkg::cmd_t                     cmd
);

  logic signed [lss_pkg::SAMPLE_W-1:0] load_limit_r;
  logic signed [lss_pkg::SAMPLE_W-1:0] offset_limit_r;
  logic signed [lss_pkg::SAMPLE_W-1:0] front_min_r;
  logic signed [lss_pkg::SAMPLE_W-1:0] front_max_r;
  logic signed [lss_pkg::SAMPLE_W-1:0] tail_min_r;
  logic signed [lss_pkg::SAMPLE_W-1:0] tail_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_limit_r   <= '0;
      offset_limit_r <= lss_pkg::OFFSET_DISABLE;
      front_min_r    <= '0;
      front_max_r    <= '0;
      tail_min_r     <= '0;
      tail_max_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        lss_pkg::CFG_LOAD_LIMIT:   load_limit_r   <= cfg_wdata[lss_pkg::SAMPLE_W-1:0];
        lss_pkg::CFG_OFFSET_LIMIT: offset_limit_r <= cfg_wdata[lss_pkg::SAMPLE_W-1:0];
        lss_pkg::CFG_FRONT_MIN:    front_min_r    <= cfg_wdata[lss_pkg::SAMPLE_W-1:0];
        lss_pkg::CFG_FRONT_MAX:    front_max_r    <= cfg_wdata[lss_pkg::SAMPLE_W-1:0];
        lss_pkg::CFG_TAIL_MIN:     tail_min_r     <= cfg_wdata[lss_pkg::SAMPLE_W-1:0];
        lss_pkg::CFG_TAIL_MAX:     tail_max_r     <= cfg_wdata[lss_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd.ev   = lss_pkg::EV_NONE;
    cmd.trig = 1'b0;
    unique case (lss_pkg::opcode_t'(opcode))
      lss_pkg::OP_EMERG:  cmd.ev = lss_pkg::EV_EMERG;
      lss_pkg::OP_MANUAL: cmd.ev = lss_pkg::EV_MANUAL;
      lss_pkg::OP_RESET:  cmd.ev = lss_pkg::EV_RESET;
      lss_pkg::OP_TRIGGER: begin
        cmd.ev   = lss_pkg::EV_READY;
        cmd.trig = 1'b1;
      end
      lss_pkg::OP_LOAD: begin
        priority if (load_limit_r > 0 && sample_value >= load_limit_r) begin
          cmd.ev = lss_pkg::EV_LOADED;
        end else if (sample_value == 0) begin
          cmd.ev = lss_pkg::EV_CLEAR;
        end else begin
          cmd.ev = lss_pkg::EV_NONE;
        end
      end
      lss_pkg::OP_OFFSET: begin
        if (offset_limit_r > lss_pkg::OFFSET_DISABLE) begin
          cmd.ev = (sample_value >= offset_limit_r) ? lss_pkg::EV_FULL : lss_pkg::EV_EMPTY;
        end
      end
      lss_pkg::OP_FRONT: begin
        if (front_min_r < front_max_r && sample_value >= front_min_r &&
            sample_value <= front_max_r) begin
          cmd.ev = lss_pkg::EV_COME;
        end
      end
      lss_pkg::OP_TAIL: begin
        if (tail_min_r < tail_max_r) begin
          priority if (sample_value >= tail_min_r && sample_value <= tail_max_r) begin
            cmd.ev = lss_pkg::EV_LEAVE;
          end else if (sample_value > tail_max_r) begin
            cmd.ev = lss_pkg::EV_GONE;
          end else begin
            cmd.ev = lss_pkg::EV_NONE;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/lss_queue.sv]
// Small FIFO of classified commands between front and back.
module lss_queue #(
  parameter int DEPTH = lss_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lss_pkg::cmd_t push_data,
  output logic          push_ready,
  input  logic          pop,
  output lss_pkg::cmd_t pop_data,
  output logic          pop_valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lss_pkg::cmd_t  mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/lss_back.sv]
// Back end: state machine, exit/entry actions and the result register.
module lss_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lss_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lss_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  lss_pkg::cmd_t                  cmd,
  input  logic                           cmd_valid,
  output logic                           cmd_pop,
  output logic                           res_valid,
  input  logic                           res_ready,
  output lss_pkg::result_t               res
);

  lss_pkg::state_t  state_r, state_nxt;
  logic             kit_r, kit_nxt;
  logic             valve_def_r;
  logic             valid_r, valid_nxt;
  lss_pkg::result_t res_r, res_nxt;
  lss_pkg::move_t   mv;
  logic             kit_eff, valves;

  assign cmd_pop   = cmd_valid & (~valid_r | res_ready);
  assign res_valid = valid_r;
  assign res       = res_r;

  always_comb begin
    mv        = lss_pkg::next_state(state_r, cmd.ev);
    kit_eff   = kit_r | cmd.trig;
    valves    = kit_eff & valve_def_r;
    state_nxt = state_r;
    kit_nxt   = kit_r;
    res_nxt   = res_r;
    valid_nxt = valid_r & ~res_ready;
    if (cmd_pop) begin
      valid_nxt             = 1'b1;
      kit_nxt               = kit_eff;
      res_nxt.event_code    = cmd.ev;
      res_nxt.lidar_enable  = cmd.trig;
      res_nxt.state_changed = mv.move;
      res_nxt.press_close   = 1'b0;
      res_nxt.press_open    = 1'b0;
      res_nxt.lidar_disable = 1'b0;
      if (mv.move) begin
        state_nxt = mv.nxt;
        res_nxt.press_close = valves &
          (state_r == lss_pkg::ST_WORKING || state_r == lss_pkg::ST_ENDING);
        res_nxt.press_open = valves &
          (mv.nxt == lss_pkg::ST_WORKING || mv.nxt == lss_pkg::ST_ENDING);
        if (mv.nxt == lss_pkg::ST_IDLE) begin
          kit_nxt               = 1'b0;
          res_nxt.lidar_disable = 1'b1;
        end
      end
      res_nxt.current_state = state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lss_pkg::ST_IDLE;
      kit_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kit_r   <= kit_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valve_def_r <= 1'b0;
    end else if (cfg_we && cfg_addr == lss_pkg::CFG_VALVE_DEF) begin
      valve_def_r <= cfg_wdata[0];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

`ifndef SYNTH
  a_no_action_without_move: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !res_r.state_changed |->
      !res_r.press_close && !res_r.press_open && !res_r.lidar_disable)
    else $error("action flagged without a transition");

  a_lidar_off_only_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && res_r.lidar_disable |-> res_r.current_state == lss_pkg::ST_IDLE && !kit_r)
    else $error("lidar off outside idle or kit still selected");

  a_open_only_into_valve_states: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && res_r.press_open |->
      res_r.current_state == lss_pkg::ST_WORKING || res_r.current_state == lss_pkg::ST_ENDING)
    else $error("open valve pressed outside working or ending");

  a_none_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && cmd.ev == lss_pkg::EV_NONE |=> state_r == $past(state_r))
    else $error("state moved on an empty event");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd_pop) |-> res_r.current_state == state_r)
    else $error("result state differs from machine state");
`endif

endmodule

[dv/tb_loading_station_sequencer.sv]
// Testbench for the loading-station sequencer: directed and random beats against a predictor.
`timescale 1ns / 1ps

module tb_loading_station_sequencer;

  // no accepted beat on either side for this many cycles means the block hung;
  // the longest legal quiet stretch is the forced sink hold-off (HOLD_CYCLES)
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 120;
  localparam int MAX_REPORTS = 40;

  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_ONE   = 32'sd65536;      // 1.0 in Q16.16

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [31:0]                    in_tdata   = '0;   // [31:0] sample_value
  logic [2:0]                     in_tuser   = '0;   // [2:0] opcode
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // [2:0] current_state, [6:3] event_code, [7] state_changed, [8] press_close,
  // [9] press_open, [10] lidar_enable, [11] lidar_disable, [15:12] zero
  logic [15:0]                    out_tdata;
  logic                           cfg_we     = 1'b0;
  logic [lss_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [lss_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;

  // model copy of the threshold registers, reset values
  logic signed [31:0] lim_load   = '0;
  logic signed [31:0] lim_offset = lss_pkg::OFFSET_DISABLE;
  logic signed [31:0] front_lo   = '0;
  logic signed [31:0] front_hi   = '0;
  logic signed [31:0] tail_lo    = '0;
  logic signed [31:0] tail_hi    = '0;
  logic               valves_wired = 1'b0;

  // model copy of the controller state
  lss_pkg::state_t station_state = lss_pkg::ST_IDLE;
  logic            kit_flag      = 1'b0;

  lss_pkg::result_t awaited_status[$];   // predicted status beats, oldest first
  int               errors     = 0;
  int               beats_seen = 0;

  bit send_gaps   = 1'b1;       // sender inserts idle bursts
  bit sink_stalls = 1'b1;       // receiver inserts stall bursts
  bit hold_req    = 1'b0;       // ask the sink for one long hold-off

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  loading_station_sequencer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Status model
  // ---------------------------------------------------------------------------

  // Commands map straight to events; samples go through the thresholds.
  function automatic lss_pkg::event_t classify_item(lss_pkg::opcode_t op,
                                                    logic signed [31:0] x);
    case (op)
      lss_pkg::OP_EMERG:   return lss_pkg::EV_EMERG;
      lss_pkg::OP_MANUAL:  return lss_pkg::EV_MANUAL;
      lss_pkg::OP_RESET:   return lss_pkg::EV_RESET;
      lss_pkg::OP_TRIGGER: return lss_pkg::EV_READY;
      lss_pkg::OP_LOAD: begin
        // load-achieved wins; an exact zero otherwise means the bay is clear
        if (lim_load > 0 && x >= lim_load) return lss_pkg::EV_LOADED;
        return (x == 0) ? lss_pkg::EV_CLEAR : lss_pkg::EV_NONE;
      end
      lss_pkg::OP_OFFSET: begin
        if (lim_offset <= lss_pkg::OFFSET_DISABLE) return lss_pkg::EV_NONE;
        return (x >= lim_offset) ? lss_pkg::EV_FULL : lss_pkg::EV_EMPTY;
      end
      lss_pkg::OP_FRONT: begin
        if (front_lo < front_hi && x >= front_lo && x <= front_hi) return lss_pkg::EV_COME;
        return lss_pkg::EV_NONE;
      end
      default: begin
        // tail: inside the window the truck is leaving, past it the truck is gone
        if (tail_lo >= tail_hi) return lss_pkg::EV_NONE;
        if (x > tail_hi) return lss_pkg::EV_GONE;
        return (x >= tail_lo) ? lss_pkg::EV_LEAVE : lss_pkg::EV_NONE;
      end
    endcase
  endfunction

  // Transition table, keyed by event; no entry returns the same state
  // (the table has no self loops, so "same state" means "not handled").
  function automatic lss_pkg::state_t next_station(lss_pkg::state_t s, lss_pkg::event_t e);
    lss_pkg::state_t n;
    n = s;
    case (e)
      lss_pkg::EV_EMERG: begin
        if (s != lss_pkg::ST_EMERG && s != lss_pkg::ST_MANUAL) n = lss_pkg::ST_EMERG;
      end
      lss_pkg::EV_MANUAL: begin
        if (s != lss_pkg::ST_EMERG && s != lss_pkg::ST_MANUAL) n = lss_pkg::ST_MANUAL;
      end
      lss_pkg::EV_RESET: begin
        if (s == lss_pkg::ST_EMERG || s == lss_pkg::ST_MANUAL) n = lss_pkg::ST_IDLE;
      end
      lss_pkg::EV_READY: if (s == lss_pkg::ST_IDLE) n = lss_pkg::ST_READY;
      lss_pkg::EV_COME:  if (s == lss_pkg::ST_READY) n = lss_pkg::ST_WORKING;
      lss_pkg::EV_LEAVE: if (s == lss_pkg::ST_WORKING) n = lss_pkg::ST_ENDING;
      lss_pkg::EV_GONE: begin
        if (s == lss_pkg::ST_WORKING || s == lss_pkg::ST_ENDING) n = lss_pkg::ST_EMERG;
        else if (s == lss_pkg::ST_PAUSED) n = lss_pkg::ST_CLEANUP;
      end
      lss_pkg::EV_LOADED: begin
        if (s == lss_pkg::ST_WORKING || s == lss_pkg::ST_ENDING || s == lss_pkg::ST_PAUSED)
          n = lss_pkg::ST_CLEANUP;
      end
      lss_pkg::EV_CLEAR: if (s == lss_pkg::ST_CLEANUP) n = lss_pkg::ST_IDLE;
      lss_pkg::EV_FULL: begin
        if (s == lss_pkg::ST_WORKING) n = lss_pkg::ST_PAUSED;
        else if (s == lss_pkg::ST_ENDING) n = lss_pkg::ST_CLEANUP;
      end
      lss_pkg::EV_EMPTY: if (s == lss_pkg::ST_PAUSED) n = lss_pkg::ST_WORKING;
      default: ;
    endcase
    return n;
  endfunction

  // One accepted beat: classify, apply trigger side effects, then exit
  // action of the old state before entry action of the new one.
  function automatic lss_pkg::result_t advance_station(lss_pkg::opcode_t op,
                                                       logic signed [31:0] x);
    lss_pkg::result_t r;
    lss_pkg::state_t  n;
    logic             valves;
    r = '0;
    r.event_code = classify_item(op, x);
    if (op == lss_pkg::OP_TRIGGER) begin
      // kit gets picked before the get-ready event is looked at
      kit_flag       = 1'b1;
      r.lidar_enable = 1'b1;
    end
    n = next_station(station_state, r.event_code);
    if (n != station_state) begin
      valves          = kit_flag & valves_wired;
      r.state_changed = 1'b1;
      r.press_close   = valves && (station_state == lss_pkg::ST_WORKING ||
                                   station_state == lss_pkg::ST_ENDING);
      r.press_open    = valves && (n == lss_pkg::ST_WORKING || n == lss_pkg::ST_ENDING);
      if (n == lss_pkg::ST_IDLE) begin
        kit_flag        = 1'b0;
        r.lidar_disable = 1'b1;
      end
      station_state = n;
    end
    r.current_state = station_state;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Uniform in [lo, hi], with the two bounds picked often to hit the compares.
  function automatic logic signed [31:0] pick_between(logic signed [31:0] lo,
                                                      logic signed [31:0] hi);
    longint span;
    span = longint'(hi) - longint'(lo) + 64'sd1;
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return hi;
      default: return 32'(longint'(lo) + longint'({$urandom}) % span);
    endcase
  endfunction

  // Mostly the beat that moves the current state along a loading cycle,
  // with values aimed at the configured windows; about one in eight is noise.
  function automatic void pick_item(output lss_pkg::opcode_t op, output logic [31:0] v);
    int coin;
    op   = lss_pkg::opcode_t'($urandom_range(0, 7));
    v    = $urandom;
    coin = $urandom_range(0, 9);
    if ($urandom_range(0, 99) >= 12) begin
      case (station_state)
        lss_pkg::ST_IDLE:                      op = lss_pkg::OP_TRIGGER;
        lss_pkg::ST_READY:                     op = lss_pkg::OP_FRONT;
        lss_pkg::ST_EMERG, lss_pkg::ST_MANUAL: op = lss_pkg::OP_RESET;
        lss_pkg::ST_CLEANUP:                   op = lss_pkg::OP_LOAD;
        default: begin
          op = (coin < 4) ? lss_pkg::OP_OFFSET :
               (coin < 7) ? lss_pkg::OP_TAIL : lss_pkg::OP_LOAD;
        end
      endcase
    end
    coin = $urandom_range(0, 9);
    case (op)
      lss_pkg::OP_LOAD: begin
        if (coin < 3 && lim_load > 0) v = pick_between(lim_load, S32_MAX);
        else if (coin < 6) v = '0;
        else if (coin < 9 && lim_load > S32_MIN) v = pick_between(S32_MIN, lim_load - 1);
      end
      lss_pkg::OP_OFFSET: begin
        if (coin < 5 && lim_offset > S32_MIN) v = pick_between(lim_offset, S32_MAX);
        else if (coin < 9 && lim_offset > S32_MIN) v = pick_between(S32_MIN, lim_offset - 1);
      end
      lss_pkg::OP_FRONT: begin
        if (coin < 8 && front_lo <= front_hi) v = pick_between(front_lo, front_hi);
      end
      lss_pkg::OP_TAIL: begin
        // past the window trips the emergency path, keep it rare
        if (coin < 7 && tail_lo <= tail_hi) v = pick_between(tail_lo, tail_hi);
        else if (coin < 9 && tail_hi < S32_MAX) v = pick_between(tail_hi + 1, S32_MAX);
      end
      default: ;
    endcase
  endfunction

  // One beat on the input stream; the prediction is made at the accepting edge.
  task automatic send_beat(lss_pkg::opcode_t op, logic [31:0] v);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    awaited_status.insert(awaited_status.size(), advance_station(op, v));
  endtask

  task automatic run_random(int count);
    lss_pkg::opcode_t op;
    logic [31:0]      v;
    repeat (count) begin
      pick_item(op, v);
      send_beat(op, v);
    end
  endtask

  // Every beat yields a status beat, so an empty queue means nothing in flight.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // cfg_we stays high across back-to-back writes; program_regs drops it.
  task automatic put_reg(lss_pkg::cfg_idx_t idx, logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      lss_pkg::CFG_LOAD_LIMIT:   lim_load     = v;
      lss_pkg::CFG_OFFSET_LIMIT: lim_offset   = v;
      lss_pkg::CFG_FRONT_MIN:    front_lo     = v;
      lss_pkg::CFG_FRONT_MAX:    front_hi     = v;
      lss_pkg::CFG_TAIL_MIN:     tail_lo      = v;
      lss_pkg::CFG_TAIL_MAX:     tail_hi      = v;
      lss_pkg::CFG_VALVE_DEF:    valves_wired = v[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic signed [31:0] load, fill_lim, f_lo, f_hi, t_lo, t_hi,
                              input logic valve);
    put_reg(lss_pkg::CFG_LOAD_LIMIT, load);
    put_reg(lss_pkg::CFG_OFFSET_LIMIT, fill_lim);
    put_reg(lss_pkg::CFG_FRONT_MIN, f_lo);
    put_reg(lss_pkg::CFG_FRONT_MAX, f_hi);
    put_reg(lss_pkg::CFG_TAIL_MIN, t_lo);
    put_reg(lss_pkg::CFG_TAIL_MAX, t_hi);
    // only bit 0 of the valve flag counts, junk above it
    put_reg(lss_pkg::CFG_VALVE_DEF, {31'($urandom), valve});
    cfg_we <= 1'b0;
  endtask

  // 100.0 target load, 2.0 fill offset, front window +-1.0, tail window 5.0..8.0
  task automatic program_typical();
    program_regs(100 * Q_ONE, 2 * Q_ONE, -Q_ONE, Q_ONE, 5 * Q_ONE, 8 * Q_ONE, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset thresholds: offset events off, load-achieved off, both windows closed.
  task automatic test_reset_thresholds();
    send_beat(lss_pkg::OP_OFFSET, 32'h0000_0000);
    send_beat(lss_pkg::OP_LOAD, 32'd5);
    send_beat(lss_pkg::OP_LOAD, 32'd0);         // load clear, idle has no entry
    send_beat(lss_pkg::OP_FRONT, 32'd0);
    send_beat(lss_pkg::OP_TAIL, 32'd1);
    wait_drained();
  endtask

  // A full loading cycle plus the command paths, one beat per transition.
  task automatic test_directed_walk();
    program_typical();
    send_beat(lss_pkg::OP_TRIGGER, 32'h0);          // idle -> ready, lidar on
    send_beat(lss_pkg::OP_TRIGGER, 32'hFFFF_FFFF);  // not handled in ready, lidar still on
    send_beat(lss_pkg::OP_FRONT, S32_MIN);          // outside the window, no event
    send_beat(lss_pkg::OP_FRONT, 32'h0);            // -> working, open valve
    send_beat(lss_pkg::OP_LOAD, 32'h0);             // load clear not handled in working
    send_beat(lss_pkg::OP_OFFSET, 2 * Q_ONE);       // full at the bound -> paused, close
    send_beat(lss_pkg::OP_TAIL, 8 * Q_ONE);         // leave not handled in paused
    send_beat(lss_pkg::OP_OFFSET, 2 * Q_ONE - 1);   // empty -> working, open
    send_beat(lss_pkg::OP_TAIL, 5 * Q_ONE);         // -> ending, both valves
    send_beat(lss_pkg::OP_LOAD, S32_MAX);           // loaded -> cleanup, close
    send_beat(lss_pkg::OP_LOAD, 32'h0);             // -> idle, lidar off, kit dropped
    send_beat(lss_pkg::OP_EMERG, 32'h0);
    send_beat(lss_pkg::OP_MANUAL, 32'h0);           // emergency only leaves on reset
    send_beat(lss_pkg::OP_RESET, 32'h0);
    send_beat(lss_pkg::OP_MANUAL, 32'h0);
    send_beat(lss_pkg::OP_RESET, 32'h0);
    send_beat(lss_pkg::OP_TRIGGER, 32'h0);
    send_beat(lss_pkg::OP_FRONT, Q_ONE);            // upper window bound
    send_beat(lss_pkg::OP_TAIL, 8 * Q_ONE + 1);     // truck gone -> emergency, close
    send_beat(lss_pkg::OP_RESET, 32'h0);
    wait_drained();
  endtask

  task automatic test_random_typical();
    program_typical();
    run_random(250);
    wait_drained();
  endtask

  // Widest windows, highest load limit, offset just above its cut-off, no valves.
  task automatic test_random_extremes();
    program_regs(S32_MAX, lss_pkg::OFFSET_DISABLE + 1, S32_MIN, S32_MAX, S32_MIN,
                 S32_MAX - 1, 1'b0);
    run_random(130);
    wait_drained();
  endtask

  // Narrowest live settings: load limit 1 LSB, offset full only at the top value.
  task automatic test_random_narrow();
    program_regs(32'sd1, S32_MAX, 32'sd0, 32'sd1, -32'sd1, 32'sd0, 1'b1);
    run_random(130);
    wait_drained();
  endtask

  // Every sample event but load clear switched off: negative load limit, lowest offset limit,
  // inverted front window, empty tail window.
  task automatic test_random_disabled();
    program_regs(S32_MIN, S32_MIN, S32_MAX, S32_MIN, 5 * Q_ONE, 5 * Q_ONE, 1'b0);
    run_random(60);
    wait_drained();
  endtask

  // Sink holds off long enough for the input queue to fill and in_tready to
  // drop while beats keep coming; then the sender waits for every result.
  task automatic test_backpressure();
    program_typical();
    send_gaps = 1'b0;
    hold_req  = 1'b1;
    run_random(40);
    send_gaps = 1'b1;
    wait_drained();
  endtask

  // Back-to-back beats with the sink always ready.
  task automatic test_no_idle();
    send_gaps   = 1'b0;
    sink_stalls = 1'b0;
    run_random(120);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: stall bursts, long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 18);
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        n = $urandom_range(1, 24);
        for (int k = 0; k < n && !hold_req; k++) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] status beat %0d: %s", $time, beats_seen, what);
  endtask

  task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0d, model says %0d", name, got, want));
  endtask

  always @(posedge clk) begin : status_check
    lss_pkg::result_t got;
    lss_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = lss_pkg::result_t'(out_tdata[11:0]);
      if (awaited_status.size() == 0) begin
        report_mismatch("status beat with nothing outstanding");
      end else begin
        want = awaited_status.pop_front();
        check_field("current_state", got.current_state, want.current_state);
        check_field("event_code", got.event_code, want.event_code);
        check_field("state_changed", got.state_changed, want.state_changed);
        check_field("press_close_valve", got.press_close, want.press_close);
        check_field("press_open_valve", got.press_open, want.press_open);
        check_field("lidar_enable", got.lidar_enable, want.lidar_enable);
        check_field("lidar_disable", got.lidar_disable, want.lidar_disable);
        check_field("tdata padding", out_tdata[15:12], 4'h0);
      end
      beats_seen++;
    end
  end

  // Hang detector: cycles without a beat accepted on either stream.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_loading_station_sequencer failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_thresholds();
    test_directed_walk();
    test_random_typical();
    test_random_extremes();
    test_random_narrow();
    test_random_disabled();
    test_backpressure();
    test_no_idle();
    wait_drained();
    if (errors == 0) begin
      $display("tb_loading_station_sequencer passed");
    end else begin
      $display("tb_loading_station_sequencer failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/lss_pkg.sv
rtl/lss_front.sv
rtl/lss_queue.sv
rtl/lss_back.sv
rtl/loading_station_sequencer.sv
dv/tb_loading_station_sequencer.sv
